// File: src/htq_pkg.sv
// Shared constants and codes for the height grid query block.
package htq_pkg;

  localparam int unsigned DEF_MAX_VERTS = 256;
  localparam int unsigned DEF_FRAC_BITS = 16;

  localparam int unsigned Q_W       = 32;
  localparam int unsigned CS_W      = 31;
  localparam int unsigned VCFG_W    = 9;
  localparam int unsigned HS_W      = 16;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FUNC_W    = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTS_ACROSS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTS_DOWN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 3'd6;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

endpackage

// File: src/htq_in_if.sv
// Request channel: function code, sample and query position.
interface htq_in_if;
  import htq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [Q_W-1:0]   sample_value;
  logic signed [Q_W-1:0]   query_x;
  logic signed [Q_W-1:0]   query_z;
  modport source (output valid, func, sample_value, query_x, query_z, input ready);
  modport sink   (input valid, func, sample_value, query_x, query_z, output ready);
endinterface

// File: src/htq_out_if.sv
// Result channel: interpolated height, valid flag and running extremes.
interface htq_out_if;
  import htq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [Q_W-1:0]   height_out;
  logic                    valid_res;
  logic signed [Q_W-1:0]   lowest_seen;
  logic signed [Q_W-1:0]   highest_seen;
  modport source (output valid, height_out, valid_res, lowest_seen, highest_seen,
                  input ready);
  modport sink   (input valid, height_out, valid_res, lowest_seen, highest_seen,
                  output ready);
endinterface

// File: src/htq_ram.sv
// Generic simple dual-port RAM with registered read.
module htq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/htq_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module htq_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] r;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign trial = {r, q[NUM_W-1]};
  assign ge    = trial >= {1'b0, d};
  assign diff  = trial - {1'b0, d};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        q   <= num;
        r   <= '0;
        d   <= den;
      end else if (run) begin
        // remainder stays below the divisor, so it fits DEN_W bits
        r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q <= {q[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: src/heightmap_triangle_height_query_core.sv
// Height grid loader and triangle interpolation query engine.
// A load request scales one raw sample by height_scale, writes it to the
// height memory and updates the running minimum and maximum. A query
// request holds the block until its result is taken into the output
// register: two bit-serial dividers, one per axis, run in parallel to
// produce the cell index and fraction, the divide state waits for their
// done flag, then a range check, four read steps on the single-read-port
// height memory that fetch the three corners, one multiply stage, one
// sum/round stage and one finish stage follow; the next request is taken
// in the cycle the result appears. Queries left of or below the grid
// origin, with a zero cell size, or before the grid is fully loaded, skip
// the divide and go straight to the finish stage. Requests are taken one
// at a time; a finished result sits in an output register while loads
// proceed, and a full output register stalls the finish stage of the next
// query.
// The height memory is not cleared; only loaded entries are ever read.
module heightmap_triangle_height_query_core #(
  parameter int unsigned MAX_VERTS_X = htq_pkg::DEF_MAX_VERTS,
  parameter int unsigned MAX_VERTS_Z = htq_pkg::DEF_MAX_VERTS,
  parameter int unsigned FRAC_BITS   = htq_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  htq_in_if.sink                             in_ch,
  htq_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [htq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [htq_pkg::CFG_W-1:0]          cfg_wdata
);
  import htq_pkg::*;

  localparam int unsigned DEPTH = MAX_VERTS_X * MAX_VERTS_Z;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned XW    = $clog2(MAX_VERTS_X + 1);
  localparam int unsigned ZW    = $clog2(MAX_VERTS_Z + 1);
  localparam int unsigned TW    = XW + ZW;
  localparam int unsigned LXW   = (XW > VCFG_W) ? XW : VCFG_W;
  localparam int unsigned LZW   = (ZW > VCFG_W) ? ZW : VCFG_W;
  localparam int unsigned NUM_W = Q_W + FRAC_BITS;
  localparam int unsigned PW    = FRAC_BITS + 1 + Q_W + 1;
  localparam int unsigned SW    = PW + 2;
  localparam int unsigned MW    = Q_W + HS_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_RD3  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  // configuration
  logic signed [Q_W-1:0] start_x, start_z;
  logic [CS_W-1:0]       cell_size_x, cell_size_z;
  logic [VCFG_W-1:0]     verts_across, verts_down;
  logic [HS_W-1:0]       height_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x      <= '0;
      start_z      <= '0;
      cell_size_x  <= CS_W'(65536);
      cell_size_z  <= CS_W'(65536);
      verts_across <= VCFG_W'(256);
      verts_down   <= VCFG_W'(256);
      height_scale <= HS_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_X:      start_x      <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_START_Z:      start_z      <= $signed(cfg_wdata[Q_W-1:0]);
        CFG_CELL_SIZE_X:  cell_size_x  <= cfg_wdata[CS_W-1:0];
        CFG_CELL_SIZE_Z:  cell_size_z  <= cfg_wdata[CS_W-1:0];
        CFG_VERTS_ACROSS: verts_across <= cfg_wdata[VCFG_W-1:0];
        CFG_VERTS_DOWN:   verts_down   <= cfg_wdata[VCFG_W-1:0];
        CFG_HEIGHT_SCALE: height_scale <= cfg_wdata[HS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped grid size
  logic [LXW-1:0] va_ext;
  logic [LZW-1:0] vd_ext;
  logic [XW-1:0]  va;
  logic [ZW-1:0]  vd;
  logic [TW-1:0]  total;

  always_comb begin
    va_ext = LXW'(verts_across);
    vd_ext = LZW'(verts_down);
    if (va_ext < LXW'(2))                va_ext = LXW'(2);
    else if (va_ext > LXW'(MAX_VERTS_X)) va_ext = LXW'(MAX_VERTS_X);
    if (vd_ext < LZW'(2))                vd_ext = LZW'(2);
    else if (vd_ext > LZW'(MAX_VERTS_Z)) vd_ext = LZW'(MAX_VERTS_Z);
    va    = va_ext[XW-1:0];
    vd    = vd_ext[ZW-1:0];
    total = TW'(va) * TW'(vd);
  end

  // load state
  logic [CW-1:0]         load_count;
  logic signed [Q_W-1:0] min_seen, max_seen;
  logic                  loaded;
  assign loaded = TW'(load_count) >= total;

  logic [3:0] st;
  logic       acc_in;
  logic [FUNC_W-1:0] func;
  assign in_ch.ready = (st == S_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign func        = in_ch.func;

  // sample scaling: round to nearest, ties up, then saturate
  logic signed [MW-1:0]  scaled_p;
  logic signed [MW-9:0]  scaled_r;
  logic signed [Q_W-1:0] scaled;
  logic                  do_load;

  always_comb begin
    scaled_p = MW'(in_ch.sample_value) * $signed({1'b0, height_scale});
    scaled_r = (MW-8)'((scaled_p + MW'(128)) >>> 8);
    if (scaled_r > (MW-8)'(Q_MAX))      scaled = Q_MAX;
    else if (scaled_r < (MW-8)'(Q_MIN)) scaled = Q_MIN;
    else                                scaled = scaled_r[Q_W-1:0];
  end

  assign do_load = acc_in && (func == FUNC_LOAD) && !loaded;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      min_seen   <= Q_MAX;
      max_seen   <= Q_MIN;
    end else if (acc_in && func == FUNC_RESTART) begin
      load_count <= '0;
      min_seen   <= Q_MAX;
      max_seen   <= Q_MIN;
    end else if (do_load) begin
      load_count <= load_count + 1'b1;
      if (scaled < min_seen) min_seen <= scaled;
      if (scaled > max_seen) max_seen <= scaled;
    end
  end

  // height memory
  logic [AW-1:0]  raddr;
  logic [Q_W-1:0] rdata;

  htq_ram #(.WIDTH(Q_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (load_count[AW-1:0]),
    .wdata (scaled),
    .raddr (raddr),
    .rdata (rdata)
  );

  // query front end
  logic signed [Q_W:0] dx, dz;
  logic                pre_ok;
  logic                div_go;
  assign dx     = (Q_W+1)'(in_ch.query_x) - (Q_W+1)'(start_x);
  assign dz     = (Q_W+1)'(in_ch.query_z) - (Q_W+1)'(start_z);
  assign pre_ok = loaded && !dx[Q_W] && !dz[Q_W] &&
                  (cell_size_x != '0) && (cell_size_z != '0);
  assign div_go = acc_in && (func == FUNC_QUERY) && pre_ok;

  logic             dx_done, dz_done;
  logic [NUM_W-1:0] qx, qz;

  htq_div #(.NUM_W(NUM_W), .DEN_W(CS_W)) u_div_x (
    .clk (clk), .rst (rst), .start (div_go),
    .num ({dx[Q_W-1:0], {FRAC_BITS{1'b0}}}), .den (cell_size_x),
    .done (dx_done), .quo (qx)
  );

  htq_div #(.NUM_W(NUM_W), .DEN_W(CS_W)) u_div_z (
    .clk (clk), .rst (rst), .start (div_go),
    .num ({dz[Q_W-1:0], {FRAC_BITS{1'b0}}}), .den (cell_size_z),
    .done (dz_done), .quo (qz)
  );

  logic [Q_W-1:0]       col, row;
  logic [FRAC_BITS-1:0] fx, fz;
  logic                 upper;
  assign col   = qx[NUM_W-1:FRAC_BITS];
  assign row   = qz[NUM_W-1:FRAC_BITS];
  assign fx    = qx[FRAC_BITS-1:0];
  assign fz    = qz[FRAC_BITS-1:0];
  assign upper = fx > fz;

  // corner fetch and interpolation
  logic [AW-1:0]          ia;
  logic signed [Q_W-1:0]  ha, hc, he;
  logic signed [PW-1:0]   p1, p2;
  logic signed [Q_W:0]    d1, d2;
  logic signed [SW-1:0]   sum, rsum;
  logic signed [Q_W-1:0]  hsat;
  logic                   vres;

  always_comb begin
    unique case (st)
      S_RD1:   raddr = ia + AW'(va) + AW'(1);
      S_RD2:   raddr = upper ? ia + AW'(1) : ia + AW'(va);
      default: raddr = ia;
    endcase
    // upper triangle: fx*(B-A) + fz*(C-B); lower: fx*(C-D) + fz*(D-A)
    if (upper) begin
      d1 = (Q_W+1)'(he) - (Q_W+1)'(ha);
      d2 = (Q_W+1)'(hc) - (Q_W+1)'(he);
    end else begin
      d1 = (Q_W+1)'(hc) - (Q_W+1)'(he);
      d2 = (Q_W+1)'(he) - (Q_W+1)'(ha);
    end
    sum  = SW'(p1) + SW'(p2) + SW'(1 << (FRAC_BITS - 1));
    rsum = (sum >>> FRAC_BITS) + SW'(ha);
    if (rsum > SW'(Q_MAX))      hsat = Q_MAX;
    else if (rsum < SW'(Q_MIN)) hsat = Q_MIN;
    else                        hsat = rsum[Q_W-1:0];
  end

  logic                  ov;
  logic signed [Q_W-1:0] oh;
  logic                  ovr;
  logic signed [Q_W-1:0] olo, ohi;
  logic signed [Q_W-1:0] hres;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ov <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (ov && out_ch.ready && st != S_FIN) ov <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (acc_in && func == FUNC_QUERY) begin
            vres <= 1'b0;
            hres <= '0;
            st   <= pre_ok ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if (dx_done) st <= S_CHK;
        end
        S_CHK: begin
          if ({1'b0, col} + (Q_W+1)'(1) >= (Q_W+1)'(va) ||
              {1'b0, row} + (Q_W+1)'(1) >= (Q_W+1)'(vd)) begin
            st <= S_FIN;
          end else begin
            ia <= AW'(row[ZW-1:0]) * AW'(va) + AW'(col[XW-1:0]);
            st <= S_RD0;
          end
        end
        S_RD0: st <= S_RD1;
        S_RD1: begin
          ha <= rdata;
          st <= S_RD2;
        end
        S_RD2: begin
          hc <= rdata;
          st <= S_RD3;
        end
        S_RD3: begin
          he <= rdata;
          st <= S_MUL;
        end
        S_MUL: begin
          p1 <= PW'($signed({1'b0, fx}) * d1);
          p2 <= PW'($signed({1'b0, fz}) * d2);
          st <= S_ADD;
        end
        S_ADD: begin
          hres <= hsat;
          vres <= 1'b1;
          st   <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!ov || out_ch.ready) begin
            ov  <= 1'b1;
            oh  <= hres;
            ovr <= vres;
            olo <= min_seen;
            ohi <= max_seen;
            st  <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = ov;
  assign out_ch.height_out   = oh;
  assign out_ch.valid_res    = ovr;
  assign out_ch.lowest_seen  = olo;
  assign out_ch.highest_seen = ohi;

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (acc_in && func == FUNC_QUERY) |=> (st != S_IDLE))
    else $error("query request did not start the sequencer");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    dx_done |-> (st == S_DIV && dz_done))
    else $error("divider finished outside the divide phase");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (load_count != '0) |-> (min_seen <= max_seen))
    else $error("running minimum above running maximum");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> ($past(st) == S_FIN))
    else $error("result raised outside the finish step");

endmodule
